// ----- hdl/ssag_pkg.sv -----
// ----------------------------------------------------------------------------
// Strided slice address generator package
// Shared constants, register codes and the word that moves down the divider
// chain.
// ----------------------------------------------------------------------------
package ssag_pkg;

  localparam int IDX_W     = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 32;
  localparam int REG_SEL_W = 2;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_IN_SHAPE,
    REG_OUT_SHAPE,
    REG_OFFSETS,
    REG_STEPS
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] SHAPE_RESET   = 64'h0001_0001_0001_0001;
  localparam logic [CFG_W-1:0] OFFSETS_RESET = 64'h0000_0000_0000_0000;
  localparam logic [CFG_W-1:0] STEPS_RESET   = 64'h0001_0001_0001_0001;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] num;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] q;
  } div_word_t;

endpackage

// ----- hdl/ssag_idx_if.sv -----
// ----------------------------------------------------------------------------
// Output index channel
// Carries the flat output element index into the address generator.
// ----------------------------------------------------------------------------
interface ssag_idx_if
  import ssag_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;

  modport source (output valid, output out_index, input ready);
  modport sink (input valid, input out_index, output ready);
endinterface

// ----- hdl/ssag_addr_if.sv -----
// ----------------------------------------------------------------------------
// Source address channel
// Carries the flat source index and its range flag out of the generator.
// ----------------------------------------------------------------------------
interface ssag_addr_if
  import ssag_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] source_index;
  logic             out_of_range;

  modport source (output valid, output source_index, output out_of_range, input ready);
  modport sink (input valid, input source_index, input out_of_range, output ready);
endinterface

// ----- hdl/strided_slice_address_gen.sv -----
// ----------------------------------------------------------------------------
// Strided slice address generator
// Maps a flat output element index to the flat source index of a strided
// slice and flags sources that fall outside the input tensor.
// ----------------------------------------------------------------------------
//   channel   dir  fields                        handshake
//   idx       in   out_index                     valid / ready
//   addr      out  source_index, out_of_range    valid / ready
//   cfg       in   cfg_index, cfg_data           cfg_we, no back-pressure
//
// One word is accepted every cycle while the spare output entry is empty.
// A word passes NUM_DIMS + 1 delay registers, 32 divider cells for each
// dimension but the innermost, and the term cell of each dimension before it
// reaches the output register. Reset clears all valid bits and loads the
// register reset values. When the output is stalled, the spare output entry
// fills and the whole chain holds until it drains.
// ----------------------------------------------------------------------------
module strided_slice_address_gen
  import ssag_pkg::*;
#(
  parameter int NUM_DIMS = 4,
  parameter int DIM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ssag_idx_if.sink             idx,
  ssag_addr_if.source          addr
);

  localparam int SW   = NUM_DIMS * DIM_BITS;
  localparam int AW   = IDX_W + DIM_BITS + 6;
  localparam int PRE  = NUM_DIMS + 1;
  localparam int CMPW = (SW > IDX_W) ? SW : IDX_W;

  logic [DIM_BITS-1:0] isz [NUM_DIMS];
  logic [DIM_BITS-1:0] off_n [NUM_DIMS];
  logic [DIM_BITS-1:0] mag [NUM_DIMS];
  logic                step_neg [NUM_DIMS];
  logic [SW-1:0]       ostr [NUM_DIMS];
  logic [SW-1:0]       itot;

  logic                 en;
  logic                 pre_v [PRE];
  logic [IDX_W-1:0]     pre_i [PRE];
  logic                 v_dim [NUM_DIMS+1];
  logic [IDX_W-1:0]     rem_dim [NUM_DIMS];
  logic signed [AW-1:0] acc_dim [NUM_DIMS+1];
  logic                 big_dim [NUM_DIMS+1];

  logic             bad;
  logic [IDX_W-1:0] lo;
  logic             out_valid;
  logic [IDX_W-1:0] out_src;
  logic             out_bad;
  logic             sp_valid;
  logic [IDX_W-1:0] sp_src;
  logic             sp_bad;
  logic             pop;
  logic             push;

  ssag_cfg #(
    .NUM_DIMS(NUM_DIMS),
    .DIM_BITS(DIM_BITS),
    .SW(SW)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .isz(isz),
    .off_n(off_n),
    .mag(mag),
    .step_neg(step_neg),
    .ostr(ostr),
    .itot(itot)
  );

  assign en        = !sp_valid;
  assign idx.ready = en;

  // The delay line gives the derived strides time to settle after a write.
  genvar p;
  for (p = 0; p < PRE; p++) begin : g_pre
    always_ff @(posedge clk) begin
      if (rst) begin
        pre_v[p] <= 1'b0;
      end else if (en) begin
        pre_v[p] <= (p == 0) ? idx.valid : pre_v[(p == 0) ? 0 : p - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        pre_i[p] <= (p == 0) ? idx.out_index : pre_i[(p == 0) ? 0 : p - 1];
      end
    end
  end

  assign v_dim[0]   = pre_v[PRE-1];
  assign rem_dim[0] = pre_i[PRE-1];
  assign acc_dim[0] = '0;
  assign big_dim[0] = 1'b0;

  genvar d, k;
  for (d = 0; d < NUM_DIMS; d++) begin : g_dim
    if (d < NUM_DIMS - 1) begin : g_div
      div_word_t            w [IDX_W+1];
      logic signed [AW-1:0] a [IDX_W+1];
      logic                 b [IDX_W+1];

      assign w[0] = '{valid: v_dim[d], num: rem_dim[d], r: '0, q: '0};
      assign a[0] = acc_dim[d];
      assign b[0] = big_dim[d];

      for (k = 0; k < IDX_W; k++) begin : g_cell
        ssag_div_cell #(
          .SW(SW),
          .AW(AW),
          .BIT(IDX_W - 1 - k)
        ) u_div (
          .clk(clk),
          .rst(rst),
          .en(en),
          .din(w[k]),
          .divisor(ostr[d]),
          .acc_in(a[k]),
          .big_in(b[k]),
          .dout(w[k+1]),
          .acc_out(a[k+1]),
          .big_out(b[k+1])
        );
      end

      ssag_term_cell #(
        .DIM_BITS(DIM_BITS),
        .AW(AW)
      ) u_term (
        .clk(clk),
        .rst(rst),
        .en(en),
        .valid_in(w[IDX_W].valid),
        .coord(w[IDX_W].q),
        .rem(w[IDX_W].r),
        .acc_in(a[IDX_W]),
        .big_in(b[IDX_W]),
        .off(off_n[d]),
        .mag(mag[d]),
        .neg(step_neg[d]),
        .isz(isz[d]),
        .valid_out(v_dim[d+1]),
        .rem_out(rem_dim[d+1]),
        .acc_out(acc_dim[d+1]),
        .big_out(big_dim[d+1])
      );
    end else begin : g_last
      ssag_term_cell #(
        .DIM_BITS(DIM_BITS),
        .AW(AW)
      ) u_term (
        .clk(clk),
        .rst(rst),
        .en(en),
        .valid_in(v_dim[d]),
        .coord(rem_dim[d]),
        .rem('0),
        .acc_in(acc_dim[d]),
        .big_in(big_dim[d]),
        .off(off_n[d]),
        .mag(mag[d]),
        .neg(step_neg[d]),
        .isz(isz[d]),
        .valid_out(v_dim[d+1]),
        .rem_out(),
        .acc_out(acc_dim[d+1]),
        .big_out(big_dim[d+1])
      );
    end
  end

  assign lo  = acc_dim[NUM_DIMS][IDX_W-1:0];
  assign bad = big_dim[NUM_DIMS] || acc_dim[NUM_DIMS][AW-1] ||
               (|acc_dim[NUM_DIMS][AW-2:IDX_W]) || (CMPW'(lo) >= CMPW'(itot));

  assign push = v_dim[NUM_DIMS] && en;
  assign pop  = out_valid && addr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sp_valid  <= 1'b0;
    end else if (sp_valid) begin
      if (pop) begin
        out_src  <= sp_src;
        out_bad  <= sp_bad;
        sp_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_src   <= bad ? '0 : lo;
        out_bad   <= bad;
        out_valid <= 1'b1;
      end else begin
        sp_src   <= bad ? '0 : lo;
        sp_bad   <= bad;
        sp_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign addr.valid        = out_valid;
  assign addr.source_index = out_src;
  assign addr.out_of_range = out_bad;

`ifndef SYNTHESIS
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    addr.valid && addr.out_of_range |-> addr.source_index == '0)
    else $error("flagged word carries a nonzero source index");

  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    sp_valid |-> out_valid)
    else $error("spare entry holds a word while the output is empty");

  a_spare_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(sp_valid) |-> $past(out_valid && !addr.ready))
    else $error("spare entry filled without an output stall");
`endif

endmodule

// ----- hdl/ssag_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four packed registers and derives clamped offsets, step
// magnitudes, output strides and the input element count.
// ----------------------------------------------------------------------------
module ssag_cfg
  import ssag_pkg::*;
#(
  parameter int NUM_DIMS = 4,
  parameter int DIM_BITS = 16,
  parameter int SW       = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [DIM_BITS-1:0]  isz [NUM_DIMS],
  output logic [DIM_BITS-1:0]  off_n [NUM_DIMS],
  output logic [DIM_BITS-1:0]  mag [NUM_DIMS],
  output logic                 step_neg [NUM_DIMS],
  output logic [SW-1:0]        ostr [NUM_DIMS],
  output logic [SW-1:0]        itot
);

  logic [CFG_W-1:0]    ishape;
  logic [CFG_W-1:0]    oshape;
  logic [CFG_W-1:0]    offsets;
  logic [CFG_W-1:0]    steps;
  logic [DIM_BITS-1:0] osz [NUM_DIMS];
  logic [SW-1:0]       istr [NUM_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      ishape  <= SHAPE_RESET;
      oshape  <= SHAPE_RESET;
      offsets <= OFFSETS_RESET;
      steps   <= STEPS_RESET;
    end else if (cfg_we && (cfg_index[CFG_IDX_W-1:REG_SEL_W] == '0)) begin
      case (cfg_reg_t'(cfg_index[REG_SEL_W-1:0]))
        REG_IN_SHAPE:  ishape  <= cfg_data;
        REG_OUT_SHAPE: oshape  <= cfg_data;
        REG_OFFSETS:   offsets <= cfg_data;
        REG_STEPS:     steps   <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar d;
  for (d = 0; d < NUM_DIMS; d++) begin : g_dim
    localparam int LO = (NUM_DIMS - 1 - d) * DIM_BITS;
    logic [DIM_BITS-1:0]        offr;
    logic [DIM_BITS-1:0]        stp;
    logic                       step_pos;
    logic signed [DIM_BITS+1:0] sz;
    logic signed [DIM_BITS+1:0] ofs;
    logic signed [DIM_BITS+1:0] hib;

    assign isz[d]      = ishape[LO +: DIM_BITS];
    assign osz[d]      = oshape[LO +: DIM_BITS];
    assign offr        = offsets[LO +: DIM_BITS];
    assign stp         = steps[LO +: DIM_BITS];
    assign step_neg[d] = stp[DIM_BITS-1];
    assign step_pos    = !stp[DIM_BITS-1] && (stp != '0);
    assign mag[d]      = stp[DIM_BITS-1] ? (~stp + 1'b1) : stp;

    always_comb begin
      sz  = signed'({2'b00, isz[d]});
      ofs = signed'({{2{offr[DIM_BITS-1]}}, offr});
      if (ofs[DIM_BITS+1]) ofs = ofs + sz;
      hib = step_pos ? sz : sz - (DIM_BITS+2)'(1);
      if (ofs > hib) ofs = hib;
      if (ofs[DIM_BITS+1]) ofs = '0;
    end

    always_ff @(posedge clk) begin
      off_n[d] <= ofs[DIM_BITS-1:0];
    end

    // Strides settle one dimension per cycle after a register write.
    if (d == NUM_DIMS - 1) begin : g_inner
      always_ff @(posedge clk) begin
        ostr[d] <= SW'(1);
        istr[d] <= SW'(1);
      end
    end else begin : g_outer
      always_ff @(posedge clk) begin
        ostr[d] <= SW'(ostr[d+1] * osz[d+1]);
        istr[d] <= SW'(istr[d+1] * isz[d+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    itot <= SW'(istr[0] * isz[0]);
  end

endmodule

// ----- hdl/ssag_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// Resolves one quotient bit of the index split for one dimension and passes
// the partial address along unchanged.
// ----------------------------------------------------------------------------
module ssag_div_cell
  import ssag_pkg::*;
#(
  parameter int SW  = 64,
  parameter int AW  = 54,
  parameter int BIT = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  div_word_t            din,
  input  logic [SW-1:0]        divisor,
  input  logic signed [AW-1:0] acc_in,
  input  logic                 big_in,
  output div_word_t            dout,
  output logic signed [AW-1:0] acc_out,
  output logic                 big_out
);

  localparam int CW = (SW > IDX_W + 1) ? SW : IDX_W + 1;

  logic [CW-1:0] rs_w;
  logic [CW-1:0] div_w;
  logic          take;
  div_word_t     nxt;

  always_comb begin
    rs_w  = CW'({din.r, din.num[BIT]});
    div_w = CW'(divisor);
    take  = (divisor != '0) && (rs_w >= div_w);
    nxt   = din;
    nxt.r = take ? IDX_W'(rs_w - div_w) : rs_w[IDX_W-1:0];
    nxt.q[BIT] = take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_out <= acc_in;
      big_out <= big_in;
    end
  end

endmodule

// ----- hdl/ssag_term_cell.sv -----
// ----------------------------------------------------------------------------
// Dimension term cell
// Folds one dimension into the running address: the address so far times the
// dimension size, plus the offset and the signed coordinate times step.
// ----------------------------------------------------------------------------
module ssag_term_cell
  import ssag_pkg::*;
#(
  parameter int DIM_BITS = 16,
  parameter int AW       = 54
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [IDX_W-1:0]     coord,
  input  logic [IDX_W-1:0]     rem,
  input  logic signed [AW-1:0] acc_in,
  input  logic                 big_in,
  input  logic [DIM_BITS-1:0]  off,
  input  logic [DIM_BITS-1:0]  mag,
  input  logic                 neg,
  input  logic [DIM_BITS-1:0]  isz,
  output logic                 valid_out,
  output logic [IDX_W-1:0]     rem_out,
  output logic signed [AW-1:0] acc_out,
  output logic                 big_out
);

  localparam int TW = IDX_W + DIM_BITS + 2;
  localparam int PW = AW + DIM_BITS + 2;

  logic                          v1, v2;
  logic [IDX_W-1:0]              rem1, rem2;
  logic signed [AW-1:0]          acc1;
  logic                          big1, big2;
  logic [IDX_W+DIM_BITS-1:0]     p1;
  logic signed [AW+DIM_BITS:0]   m2;
  logic signed [TW-1:0]          t2;
  logic signed [TW-1:0]          offx;
  logic signed [TW-1:0]          p1x;
  logic signed [PW-1:0]          v;
  logic [PW-AW+1:0]              hi;
  logic                          big_next;

  assign offx = signed'(TW'(off));
  assign p1x  = signed'(TW'(p1));
  assign v    = m2 + t2;
  assign hi   = v[PW-1:AW-2];
  assign big_next = ((big2 && (isz != '0)) || !((&hi) || (~|hi)));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= valid_in;
      v2        <= v1;
      valid_out <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1      <= coord * mag;
      rem1    <= rem;
      acc1    <= acc_in;
      big1    <= big_in;
      m2      <= acc1 * signed'({1'b0, isz});
      t2      <= neg ? (offx - p1x) : (offx + p1x);
      rem2    <= rem1;
      big2    <= big1;
      acc_out <= v[AW-1:0];
      big_out <= big_next;
      rem_out <= rem2;
    end
  end

endmodule
